@@ rtl/register_vm_instruction_execute_top_assert.svh @@
// ----------------------------------------------------------------------------
// Register VM assertion macros
// Shared concurrent assertion macros for the register VM execute block.
// ----------------------------------------------------------------------------
`ifndef REGISTER_VM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RVMIE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property does not hold");
`define RVMIE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define RVMIE_ASSERT(lbl, prop)
`define RVMIE_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ rtl/rvmie_pkg.sv @@
// ----------------------------------------------------------------------------
// Register VM package
// Types, codes and helper functions shared by the register VM execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvmie_pkg;

  localparam int unsigned NumRegsDef    = 16;
  localparam int unsigned StackBytesDef = 4096;
  localparam int unsigned DataBytesDef  = 4096;
  localparam int unsigned CfgW          = 13;

  localparam logic [31:0] StkTop  = 32'h7fff_ffff;
  localparam logic [31:0] DatBase = 32'h1000_0000;
  localparam logic [31:0] AllOnes = 32'hffff_ffff;
  localparam logic [31:0] SignBit = 32'h8000_0000;

  localparam logic [3:0] CondAlways = 4'd0;
  localparam logic [3:0] CondLast   = 4'd10;

  typedef enum logic [4:0] {
    OP_KILL, OP_INC, OP_DEC, OP_NEG, OP_PUSH, OP_POP, OP_MOV, OP_ADD,
    OP_SUB, OP_MUL, OP_DIV, OP_SDIV, OP_MOD, OP_SMOD, OP_AND, OP_OR,
    OP_XOR, OP_LSL, OP_LSR, OP_ASR, OP_LOAD, OP_STORE, OP_CMP, OP_LEA,
    OP_JUMP, OP_CALL, OP_RET, OP_HALT, OP_OUT
  } op_e;

  typedef enum logic [1:0] {ST_RUN, ST_HALT, ST_STOP, ST_TRAP} status_e;
  typedef enum logic [1:0] {MODE_IMM, MODE_REG, MODE_REG_IMM} mode_e;
  typedef enum logic [1:0] {SZ_BYTE, SZ_HALF, SZ_WORD} size_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_EXEC, S_DIV, S_MEM, S_MRD, S_MRW,
    S_LDFIN, S_POPSP, S_PC, S_DONE
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [4:0]         operation;
    logic [3:0]         condition;
    logic               first_from_imm;
    logic [1:0]         second_mode;
    logic [1:0]         access_size;
    logic               sign_extend;
    logic [3:0]         dest_reg;
    logic [3:0]         src_reg;
    logic signed [31:0] imm_first;
    logic signed [31:0] imm_second;
    logic [31:0]        target;
  } in_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic [1:0]         status;
    logic signed [31:0] dest_value;
    logic [31:0]        cycle_count;
  } out_t;

  function automatic logic [9:0] flags_of(logic [31:0] x, logic [31:0] y);
    logic [31:0] sx;
    logic [31:0] sy;
    sx = x ^ SignBit;
    sy = y ^ SignBit;
    return {x < y, x <= y, x > y, x >= y, sx < sy, sx <= sy, sx > sy, sx >= sy,
            x == y, x != y};
  endfunction

  function automatic logic cond_holds(logic [3:0] c, logic [9:0] f);
    if (c == CondAlways) begin
      return 1'b1;
    end
    if (c > CondLast) begin
      return 1'b0;
    end
    return f[c - 4'd1];
  endfunction

endpackage

`default_nettype wire

@@ rtl/rvmie_div.sv @@
// ----------------------------------------------------------------------------
// Register VM divider
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_vm_instruction_execute_top_assert.svh"

module rvmie_div import rvmie_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      quotient_o,
  output logic [31:0]      remainder_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = 5'd31;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `RVMIE_ASSERT(a_start_busy, start_i |=> busy_q)
  `RVMIE_ASSERT_NEVER(a_done_busy, done_q && busy_q)
  `RVMIE_ASSERT(a_rem_small, (done_q && dvs_q != '0) |-> (rem_q < dvs_q))

endmodule

`default_nettype wire

@@ rtl/register_vm_instruction_execute_top.sv @@
// ----------------------------------------------------------------------------
// Register VM instruction execute
// Executes one decoded instruction per beat against a register file, a stack
// region and a data region, and returns pc, status, destination and cycles.
// ----------------------------------------------------------------------------
// An instruction passes through register read, operand read, execute, pc
// update and result stages. Stores add a write step per byte, loads add a
// read and a capture step per byte plus a writeback step, and pops add a
// stack pointer step on top of that, since both memories have one byte-wide
// port. Divide and modulo wait in the shared bit-serial divider. Preloads
// and instructions seen after a stop go straight to the result stage. One
// item is in work at a time; the result register lets the next item enter
// while a result waits to be taken.
`default_nettype none

`include "register_vm_instruction_execute_top_assert.svh"

module register_vm_instruction_execute_top import rvmie_pkg::*; #(
  parameter int unsigned NUM_REGS    = NumRegsDef,
  parameter int unsigned STACK_BYTES = StackBytesDef,
  parameter int unsigned DATA_BYTES  = DataBytesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output out_t                 out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned RW  = $clog2(NUM_REGS);
  localparam int unsigned SAW = $clog2(STACK_BYTES);
  localparam int unsigned DAW = $clog2(DATA_BYTES);
  localparam logic [RW-1:0] R_PC  = RW'(NUM_REGS - 1);
  localparam logic [RW-1:0] R_LR  = RW'(NUM_REGS - 2);
  localparam logic [RW-1:0] R_SP  = RW'(NUM_REGS - 3);
  localparam logic [RW-1:0] R_FP  = RW'(NUM_REGS - 4);
  localparam logic [RW-1:0] R_CC  = RW'(NUM_REGS - 5);
  localparam logic [RW-1:0] R_CYC = RW'(NUM_REGS - 6);
  localparam logic [5:0]  NrW   = 6'(NUM_REGS);
  localparam logic [31:0] StkN  = 32'(STACK_BYTES);
  localparam logic [31:0] DatN  = 32'(DATA_BYTES);
  localparam logic [31:0] StkLow = StkTop - StkN;

  function automatic logic [RW-1:0] reg_idx(logic [3:0] r);
    logic [5:0] t;
    t = {2'b00, r};
    if (t >= NrW) begin
      t = t - NrW;
    end
    return t[RW-1:0];
  endfunction

  state_e      state_q, state_d;
  in_t         item_q, item_d;
  logic [31:0] a_q, a_d, b_q, b_d, val_q, val_d, off_q, off_d;
  logic [31:0] rf_q [NUM_REGS];
  logic [31:0] rf_d [NUM_REGS];
  logic        stopped_q, stopped_d, jumped_q, jumped_d, stk_sel_q, stk_sel_d;
  logic        neg_q, neg_d;
  logic [1:0]  stat_q, stat_d, code_q, code_d;
  logic [2:0]  nb_q, nb_d, k_q, k_d;
  out_t        out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [CfgW-1:0] dsize_q;

  logic [RW-1:0] d_idx, s_idx, rd_addr;
  logic [31:0]   rd_data, mem_off, addr, so, dof, lim, nn, prod, ldv, dres;
  logic [2:0]    nsz;
  logic          stk_ok, dat_ok, in_acc;
  logic [4:0]    sh;
  op_e           op;

  logic          div_start, div_busy, div_done;
  logic [31:0]   div_a, div_b, div_q, div_r;

  logic [7:0]    stk_mem [STACK_BYTES];
  logic [7:0]    dat_mem [DATA_BYTES];
  logic [7:0]    stk_rdata_q, dat_rdata_q, mem_wdata, rdat;
  logic          stk_we, dat_we;
  logic [SAW-1:0] stk_addr;
  logic [DAW-1:0] dat_addr;

  rvmie_div u_div (
    .clk_i,
    .rst_ni,
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign d_idx      = reg_idx(item_q.dest_reg);
  assign s_idx      = reg_idx(item_q.src_reg);
  assign rd_addr    = (state_q == S_RDB) ? s_idx : d_idx;
  assign rd_data    = rf_q[rd_addr];
  assign op         = op_e'(item_q.operation);
  assign sh         = b_q[4:0];
  assign prod       = a_q * b_q;
  assign mem_off    = off_q + {29'b0, k_q};
  assign rdat       = stk_sel_q ? stk_rdata_q : dat_rdata_q;

  always_comb begin
    case (size_e'(item_q.access_size))
      SZ_BYTE: nsz = 3'd1;
      SZ_HALF: nsz = 3'd2;
      default: nsz = 3'd4;
    endcase
    if (op == OP_PUSH) begin
      addr = rf_q[R_SP] - 32'd4;
      nn   = 32'd4;
    end else if (op == OP_POP) begin
      addr = rf_q[R_SP];
      nn   = 32'd4;
    end else begin
      addr = b_q;
      nn   = {29'b0, nsz};
    end
    so     = addr - StkLow;
    stk_ok = (so < StkN) && ((StkN - so) >= nn);
    lim    = ({19'b0, dsize_q} < DatN) ? {19'b0, dsize_q} : DatN;
    dof    = addr - DatBase;
    dat_ok = (dof < lim) && ((lim - dof) >= nn);
  end

  always_comb begin
    ldv = val_q;
    if (op == OP_LOAD && item_q.sign_extend) begin
      if (nb_q == 3'd1 && val_q[7]) begin
        ldv = val_q | 32'hffff_ff00;
      end else if (nb_q == 3'd2 && val_q[15]) begin
        ldv = val_q | 32'hffff_0000;
      end
    end
    if (op == OP_DIV || op == OP_SDIV) begin
      dres = neg_q ? 32'd0 - div_q : div_q;
    end else begin
      dres = neg_q ? 32'd0 - div_r : div_r;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    off_d       = off_q;
    rf_d        = rf_q;
    stopped_d   = stopped_q;
    stat_d      = stat_q;
    jumped_d    = jumped_q;
    code_d      = code_q;
    stk_sel_d   = stk_sel_q;
    neg_d       = neg_q;
    nb_d        = nb_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;
    div_a       = a_q;
    div_b       = b_q;
    stk_we      = 1'b0;
    dat_we      = 1'b0;
    mem_wdata   = val_q[7:0];
    stk_addr    = mem_off[SAW-1:0];
    dat_addr    = mem_off[DAW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        dat_addr  = in_data_i.imm_second[DAW-1:0];
        mem_wdata = in_data_i.imm_first[7:0];
        if (in_acc) begin
          item_d   = in_data_i;
          code_d   = ST_RUN;
          jumped_d = 1'b0;
          if (in_data_i.req_type) begin
            dat_we  = ($unsigned(in_data_i.imm_second) < DatN);
            state_d = S_DONE;
          end else if (stopped_q) begin
            state_d = S_DONE;
          end else begin
            rf_d[R_CYC] = rf_q[R_CYC] + 32'd1;
            state_d     = S_RDA;
          end
        end
      end
      S_RDA: begin
        a_d     = rd_data;
        state_d = S_RDB;
      end
      S_RDB: begin
        case (mode_e'(item_q.second_mode))
          MODE_IMM: b_d = item_q.imm_second;
          MODE_REG: b_d = rd_data;
          default:  b_d = rd_data + item_q.imm_second;
        endcase
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d   = S_PC;
        stk_sel_d = stk_ok;
        off_d     = stk_ok ? so : dof;
        k_d       = '0;
        val_d     = '0;
        nb_d      = nn[2:0];
        neg_d     = 1'b0;
        case (op)
          OP_KILL:  code_d = ST_STOP;
          OP_INC:   rf_d[d_idx] = a_q + 32'd1;
          OP_DEC:   rf_d[d_idx] = a_q - 32'd1;
          OP_NEG:   rf_d[d_idx] = 32'd0 - a_q;
          OP_PUSH: begin
            if (!stk_ok && !dat_ok) begin
              code_d = ST_TRAP;
            end else begin
              rf_d[R_SP] = addr;
              val_d      = (d_idx == R_SP) ? addr : a_q;
              state_d    = S_MEM;
            end
          end
          OP_POP, OP_LOAD: begin
            if (!stk_ok && !dat_ok) begin
              code_d = ST_TRAP;
            end else begin
              state_d = S_MRD;
            end
          end
          OP_STORE: begin
            if (!stk_ok && !dat_ok) begin
              code_d = ST_TRAP;
            end else begin
              val_d   = item_q.first_from_imm ? item_q.imm_first : a_q;
              state_d = S_MEM;
            end
          end
          OP_MOV: begin
            if (cond_holds(item_q.condition, rf_q[R_CC][9:0])) begin
              rf_d[d_idx] = b_q;
            end
          end
          OP_ADD: rf_d[d_idx] = a_q + b_q;
          OP_SUB: rf_d[d_idx] = a_q - b_q;
          OP_MUL: rf_d[d_idx] = prod;
          OP_AND: rf_d[d_idx] = a_q & b_q;
          OP_OR:  rf_d[d_idx] = a_q | b_q;
          OP_XOR: rf_d[d_idx] = a_q ^ b_q;
          OP_LSL: rf_d[d_idx] = a_q << sh;
          OP_LSR: rf_d[d_idx] = a_q >> sh;
          OP_ASR: rf_d[d_idx] = 32'($signed(a_q) >>> sh);
          OP_DIV, OP_SDIV: begin
            if (b_q == '0) begin
              rf_d[d_idx] = '0;
            end else if (b_q == AllOnes) begin
              rf_d[d_idx] = 32'd0 - a_q;
            end else begin
              if (op == OP_SDIV) begin
                div_a = a_q[31] ? 32'd0 - a_q : a_q;
                div_b = b_q[31] ? 32'd0 - b_q : b_q;
                neg_d = a_q[31] ^ b_q[31];
              end
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_MOD: begin
            if (b_q != '0) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_SMOD: begin
            if (b_q == AllOnes) begin
              rf_d[d_idx] = '0;
            end else if (b_q != '0) begin
              div_a     = a_q[31] ? 32'd0 - a_q : a_q;
              div_b     = b_q[31] ? 32'd0 - b_q : b_q;
              neg_d     = a_q[31];
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_CMP: begin
            rf_d[R_CC] = {22'b0, flags_of(item_q.first_from_imm ? item_q.imm_first : a_q,
                                          b_q)};
          end
          OP_LEA: rf_d[d_idx] = item_q.target + item_q.imm_second;
          OP_JUMP: begin
            if (cond_holds(item_q.condition, rf_q[R_CC][9:0])) begin
              rf_d[R_PC] = item_q.target;
              jumped_d   = 1'b1;
            end
          end
          OP_CALL: begin
            rf_d[R_LR] = rf_q[R_PC];
            rf_d[R_PC] = item_q.target;
            jumped_d   = 1'b1;
          end
          OP_RET: begin
            if (rf_q[R_LR][31]) begin
              code_d = ST_STOP;
            end else begin
              rf_d[R_PC] = rf_q[R_LR];
            end
          end
          OP_HALT: code_d = ST_HALT;
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          rf_d[d_idx] = dres;
          state_d     = S_PC;
        end
      end
      S_MEM: begin
        stk_we = stk_sel_q;
        dat_we = !stk_sel_q;
        val_d  = val_q >> 8;
        k_d    = k_q + 3'd1;
        if (k_q == nb_q - 3'd1) begin
          state_d = S_PC;
        end
      end
      S_MRD: begin
        state_d = S_MRW;
      end
      S_MRW: begin
        val_d = val_q | ({24'b0, rdat} << {k_q, 3'b000});
        k_d   = k_q + 3'd1;
        if (k_q == nb_q - 3'd1) begin
          state_d = S_LDFIN;
        end else begin
          state_d = S_MRD;
        end
      end
      S_LDFIN: begin
        rf_d[d_idx] = ldv;
        state_d     = (op == OP_POP) ? S_POPSP : S_PC;
      end
      S_POPSP: begin
        rf_d[R_SP] = rf_q[R_SP] + 32'd4;
        state_d    = S_PC;
      end
      S_PC: begin
        if (code_q != ST_RUN) begin
          stopped_d = 1'b1;
          stat_d    = code_q;
        end else if (!jumped_q) begin
          rf_d[R_PC] = rf_q[R_PC] + 32'd1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.next_pc     = rf_q[R_PC];
          out_d.status      = stopped_q ? stat_q : ST_RUN;
          out_d.dest_value  = rd_data;
          out_d.cycle_count = rf_q[R_CYC];
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stopped_q   <= 1'b0;
      stat_q      <= ST_RUN;
      out_valid_q <= 1'b0;
      dsize_q     <= '0;
      code_q      <= ST_RUN;
      jumped_q    <= 1'b0;
      k_q         <= '0;
      nb_q        <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (RW'(i) == R_FP || RW'(i) == R_SP) begin
          rf_q[i] <= StkTop;
        end else if (RW'(i) == R_LR) begin
          rf_q[i] <= AllOnes;
        end else begin
          rf_q[i] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      stopped_q   <= stopped_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      code_q      <= code_d;
      jumped_q    <= jumped_d;
      k_q         <= k_d;
      nb_q        <= nb_d;
      rf_q        <= rf_d;
      if (cfg_we_i) begin
        dsize_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    a_q       <= a_d;
    b_q       <= b_d;
    val_q     <= val_d;
    off_q     <= off_d;
    stk_sel_q <= stk_sel_d;
    neg_q     <= neg_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= mem_wdata;
    end
    stk_rdata_q <= stk_mem[stk_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) begin
      dat_mem[dat_addr] <= mem_wdata;
    end
    dat_rdata_q <= dat_mem[dat_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RVMIE_ASSERT(a_stop_sticky, stopped_q |=> stopped_q)
  `RVMIE_ASSERT(a_preload_cyc, (in_acc && in_data_i.req_type) |=> $stable(rf_q[R_CYC]))
  `RVMIE_ASSERT_NEVER(a_div_idle, in_ready_o && div_busy)

endmodule

`default_nettype wire

@@ tb/register_vm_instruction_execute_checker.sv @@
// ----------------------------------------------------------------------------
// Register VM execute checker
// Watches the instruction and result channels and the configuration port,
// predicts each result from its own copy of the register file and memories,
// and compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module register_vm_instruction_execute_checker import rvmie_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_ready_i,
  input  wire in_t             in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_ready_i,
  input  wire out_t            out_data_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output int                   mismatches_o,
  output int                   beats_in_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RegPc  = 15;
  localparam int RegLr  = 14;
  localparam int RegSp  = 13;
  localparam int RegFp  = 12;
  localparam int RegCc  = 11;
  localparam int RegCyc = 10;
  localparam int MemBytes = 4096;
  localparam logic [31:0] StkLow = StkTop - MemBytes;
  localparam int RegionNone  = 0;
  localparam int RegionStack = 1;
  localparam int RegionData  = 2;

  logic [31:0] regs [16];
  logic [7:0]  stk_mem [MemBytes];
  logic [7:0]  dat_mem [MemBytes];
  bit          stk_written [MemBytes];
  bit          dat_written [MemBytes];
  bit          vm_stopped;
  logic [1:0]  stop_code;
  logic [12:0] data_size;
  out_t        expected_results [$];

  function automatic int find_region(logic [31:0] addr, int unsigned n,
                                     output int unsigned off);
    logic [31:0] o;
    logic [31:0] lim;
    lim = (data_size < MemBytes) ? 32'(data_size) : MemBytes;
    off = 0;
    o = addr - StkLow;
    if (o < MemBytes && MemBytes - o >= n) begin
      off = o;
      return RegionStack;
    end
    o = addr - DatBase;
    if (o < lim && lim - o >= n) begin
      off = o;
      return RegionData;
    end
    return RegionNone;
  endfunction

  function automatic bit bytes_known(int region, int unsigned off, int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (region == RegionStack && !stk_written[off + k]) return 1'b0;
      if (region == RegionData && !dat_written[off + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] mem_read(int region, int unsigned off, int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int unsigned k = 0; k < n; k++) begin
      v |= 32'(region == RegionStack ? stk_mem[off + k] : dat_mem[off + k]) << (8 * k);
    end
    return v;
  endfunction

  task automatic mem_write(int region, int unsigned off, logic [31:0] v, int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (region == RegionStack) begin
        stk_mem[off + k] = v[8*k +: 8];
        stk_written[off + k] = 1'b1;
      end else begin
        dat_mem[off + k] = v[8*k +: 8];
        dat_written[off + k] = 1'b1;
      end
    end
  endtask

  function automatic logic [31:0] operand_b(in_t x, logic [31:0] cyc_next);
    logic [31:0] rs;
    rs = (x.src_reg == RegCyc) ? cyc_next : regs[x.src_reg];
    case (x.second_mode)
      MODE_IMM: return x.imm_second;
      MODE_REG: return rs;
      default:  return rs + x.imm_second;
    endcase
  endfunction

  function automatic int unsigned access_bytes(logic [1:0] sz);
    return sz == SZ_BYTE ? 1 : (sz == SZ_HALF ? 2 : 4);
  endfunction

  // True when the instruction neither stops the machine nor reads a byte
  // that was never written.
  function automatic bit item_is_safe(in_t x);
    logic [31:0] b;
    int unsigned off;
    int unsigned n;
    int rg;
    if (x.req_type || vm_stopped) return 1'b1;
    b = operand_b(x, regs[RegCyc] + 1);
    n = access_bytes(x.access_size);
    case (x.operation)
      OP_KILL, OP_HALT: return 1'b0;
      OP_RET:   return !regs[RegLr][31];
      OP_PUSH:  return find_region(regs[RegSp] - 4, 4, off) != RegionNone;
      OP_POP: begin
        rg = find_region(regs[RegSp], 4, off);
        return rg != RegionNone && bytes_known(rg, off, 4);
      end
      OP_LOAD: begin
        rg = find_region(b, n, off);
        return rg != RegionNone && bytes_known(rg, off, n);
      end
      OP_STORE: return find_region(b, n, off) != RegionNone;
      default:  return 1'b1;
    endcase
  endfunction

  function automatic logic [9:0] compare_flags(logic [31:0] x, logic [31:0] y);
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    xs = x;
    ys = y;
    return {x < y, x <= y, x > y, x >= y, xs < ys, xs <= ys, xs > ys, xs >= ys,
            x == y, x != y};
  endfunction

  function automatic bit condition_met(logic [3:0] c);
    if (c == CondAlways) return 1'b1;
    if (c > CondLast) return 1'b0;
    return regs[RegCc][c - 1];
  endfunction

  task automatic execute_item(in_t x);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [1:0]  code;
    int unsigned n;
    int unsigned off;
    int          rg;
    int          d;
    bit          jumped;
    out_t        r;
    d = x.dest_reg;
    code = ST_RUN;
    jumped = 1'b0;
    if (x.req_type) begin
      if ($unsigned(x.imm_second) < MemBytes) begin
        dat_mem[x.imm_second[11:0]] = x.imm_first[7:0];
        dat_written[x.imm_second[11:0]] = 1'b1;
      end
    end else if (!vm_stopped) begin
      regs[RegCyc] += 1;
      a = regs[d];
      b = operand_b(x, regs[RegCyc]);
      n = access_bytes(x.access_size);
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      case (x.operation)
        OP_KILL:  code = ST_STOP;
        OP_INC:   regs[d] = a + 1;
        OP_DEC:   regs[d] = a - 1;
        OP_NEG:   regs[d] = -a;
        OP_PUSH: begin
          v = regs[RegSp] - 4;
          rg = find_region(v, 4, off);
          if (rg == RegionNone) begin
            code = ST_TRAP;
          end else begin
            regs[RegSp] = v;
            mem_write(rg, off, regs[d], 4);
          end
        end
        OP_POP: begin
          rg = find_region(regs[RegSp], 4, off);
          if (rg == RegionNone) begin
            code = ST_TRAP;
          end else begin
            regs[d] = mem_read(rg, off, 4);
            regs[RegSp] += 4;
          end
        end
        OP_MOV:  if (condition_met(x.condition)) regs[d] = b;
        OP_ADD:  regs[d] = a + b;
        OP_SUB:  regs[d] = a - b;
        OP_MUL:  regs[d] = a * b;
        OP_DIV:  regs[d] = (b == 0) ? 0 : ((b == AllOnes) ? -a : a / b);
        OP_SDIV: begin
          if (b == 0) regs[d] = 0;
          else if (b == AllOnes) regs[d] = -a;
          else regs[d] = (a[31] ^ b[31]) ? -(ma / mb) : ma / mb;
        end
        OP_MOD:  if (b != 0) regs[d] = a % b;
        OP_SMOD: begin
          if (b == AllOnes) regs[d] = 0;
          else if (b != 0) regs[d] = a[31] ? -(ma % mb) : ma % mb;
        end
        OP_AND:  regs[d] = a & b;
        OP_OR:   regs[d] = a | b;
        OP_XOR:  regs[d] = a ^ b;
        OP_LSL:  regs[d] = a << b[4:0];
        OP_LSR:  regs[d] = a >> b[4:0];
        OP_ASR:  regs[d] = $signed(a) >>> b[4:0];
        OP_LOAD: begin
          rg = find_region(b, n, off);
          if (rg == RegionNone) begin
            code = ST_TRAP;
          end else begin
            v = mem_read(rg, off, n);
            if (x.sign_extend && n == 1 && v[7]) v |= 32'hffff_ff00;
            if (x.sign_extend && n == 2 && v[15]) v |= 32'hffff_0000;
            regs[d] = v;
          end
        end
        OP_STORE: begin
          rg = find_region(b, n, off);
          if (rg == RegionNone) code = ST_TRAP;
          else mem_write(rg, off, x.first_from_imm ? x.imm_first : a, n);
        end
        OP_CMP:  regs[RegCc] = 32'(compare_flags(x.first_from_imm ? x.imm_first : a, b));
        OP_LEA:  regs[d] = x.target + x.imm_second;
        OP_JUMP: begin
          if (condition_met(x.condition)) begin
            regs[RegPc] = x.target;
            jumped = 1'b1;
          end
        end
        OP_CALL: begin
          regs[RegLr] = regs[RegPc];
          regs[RegPc] = x.target;
          jumped = 1'b1;
        end
        OP_RET: begin
          if (regs[RegLr][31]) code = ST_STOP;
          else regs[RegPc] = regs[RegLr];
        end
        OP_HALT: code = ST_HALT;
        default: ;
      endcase
      if (code != ST_RUN) begin
        vm_stopped = 1'b1;
        stop_code = code;
      end else if (!jumped) begin
        regs[RegPc] += 1;
      end
    end
    r.next_pc = regs[RegPc];
    r.status = vm_stopped ? stop_code : ST_RUN;
    r.dest_value = regs[d];
    r.cycle_count = regs[RegCyc];
    expected_results.push_back(r);
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with no instruction outstanding");
      mismatches_o++;
      return;
    end
    want = expected_results.pop_front();
    if (got.next_pc !== want.next_pc) begin
      $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
      mismatches_o++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches_o++;
    end
    if (got.dest_value !== want.dest_value) begin
      $error("dest_value: expected %h, got %h", want.dest_value, got.dest_value);
      mismatches_o++;
    end
    if (got.cycle_count !== want.cycle_count) begin
      $error("cycle_count: expected %h, got %h", want.cycle_count, got.cycle_count);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      regs[RegFp] = StkTop;
      regs[RegSp] = StkTop;
      regs[RegLr] = AllOnes;
      foreach (stk_written[i]) stk_written[i] = 1'b0;
      foreach (dat_written[i]) dat_written[i] = 1'b0;
      vm_stopped = 1'b0;
      stop_code = ST_RUN;
      data_size = '0;
      expected_results.delete();
      mismatches_o = 0;
      beats_in_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) data_size = cfg_wdata_i;
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) begin
        execute_item(in_data_i);
        beats_in_o++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Register VM execute testbench
// Drives directed and random instruction streams, byte preloads and data
// region sizes into the execute block under several idle and stall patterns,
// and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module tb import rvmie_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] RegSp = 4'd13;
  localparam logic [3:0] RegLr = 4'd14;
  localparam logic [3:0] CondGt = 4'd4;
  localparam logic [3:0] CondNever = 4'd12;
  localparam logic [4:0] OpUnused = 5'd31;
  localparam int NumPhases = 4;
  localparam int ItemsPerPhase = 480;
  localparam int WatchdogLimit = 4000;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid;
  logic            in_ready;
  in_t             in_data;
  logic            out_valid;
  logic            out_ready;
  out_t            out_data;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;
  int              mismatches;
  int              beats_in;
  int              pending;
  int              send_idle;
  int              recv_stall;
  int              hold_cycles;
  int              quiet_cycles;

  always #4 clk_i = ~clk_i;

  register_vm_instruction_execute_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  register_vm_instruction_execute_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .mismatches_o(mismatches),
    .beats_in_o  (beats_in),
    .pending_o   (pending)
  );

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_t mk(logic [4:0] op, logic [3:0] d, logic [3:0] s,
                             logic [1:0] mode, logic [31:0] i2);
    in_t x;
    x = '0;
    x.operation = op;
    x.dest_reg = d;
    x.src_reg = s;
    x.second_mode = mode;
    x.imm_second = i2;
    x.access_size = SZ_WORD;
    return x;
  endfunction

  function automatic in_t preload(logic [31:0] off, logic [31:0] value);
    in_t x;
    x = mk(OP_OUT, 4'd0, 4'd0, MODE_IMM, off);
    x.req_type = 1'b1;
    x.imm_first = value;
    return x;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return AllOnes;
      3: return SignBit;
      4: return StkTop;
      5: return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_instr();
    in_t x;
    logic [31:0] sp;
    sp = u_checker.regs[RegSp];
    if ((sp > StkTop || sp < StkTop - 4000) && $urandom_range(0, 1) == 0) begin
      return mk(OP_MOV, RegSp, 4'd0, MODE_IMM, StkTop - 4 * $urandom_range(0, 500));
    end
    x.req_type = ($urandom_range(0, 9) == 0);
    x.operation = $urandom_range(0, 31);
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 3))
        0: x.operation = OP_PUSH;
        1: x.operation = OP_POP;
        2: x.operation = OP_LOAD;
        default: x.operation = OP_STORE;
      endcase
    end
    x.condition = $urandom_range(0, 15);
    x.first_from_imm = $urandom_range(0, 1);
    x.second_mode = $urandom_range(0, 3);
    x.access_size = $urandom_range(0, 3);
    x.sign_extend = $urandom_range(0, 1);
    x.dest_reg = $urandom_range(0, 15);
    x.src_reg = $urandom_range(0, 15);
    x.imm_first = rand_word();
    x.imm_second = rand_word();
    x.target = $urandom_range(0, 1) ? rand_word() : $urandom;
    if (x.req_type) begin
      x.imm_second = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 4095);
    end else begin
      if ((x.operation == OP_LOAD || x.operation == OP_STORE) && $urandom_range(0, 4) != 0) begin
        x.second_mode = MODE_IMM;
        if ($urandom_range(0, 1) == 0) x.imm_second = sp + $urandom_range(0, 16);
        else x.imm_second = DatBase + $urandom_range(0, 4095);
      end
      if (x.dest_reg == RegSp && x.operation != OP_PUSH && x.operation != OP_POP
          && $urandom_range(0, 3) != 0) begin
        x.dest_reg = $urandom_range(0, 9);
      end
    end
    return x;
  endfunction

  function automatic in_t safe_instr();
    in_t x;
    for (int k = 0; k < 40; k++) begin
      x = rand_instr();
      if (u_checker.item_is_safe(x)) return x;
    end
    return mk(OP_OUT, $urandom_range(0, 15), 4'd0, MODE_IMM, $urandom);
  endfunction

  task automatic send_item(in_t x);
    int n;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= x;
    n = beats_in;
    while (beats_in == n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_data_size(logic [CfgW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_t x;
    int sends [NumPhases];
    int stalls [NumPhases];
    logic [CfgW-1:0] sizes [NumPhases];
    sends = '{0, 63, 0, 30};
    stalls = '{0, 0, 63, 30};
    sizes = '{13'd8191, 13'd300, 13'd0, 13'd4096};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_data_size(13'd4096);

    send_item(preload(32'd0, 32'h80));
    send_item(preload(32'd1, 32'hff));
    send_item(preload(32'd2, 32'h7f));
    send_item(preload(32'd3, 32'h01));
    send_item(preload(AllOnes, 32'h55));
    x = mk(OP_LOAD, 4'd3, 4'd0, MODE_IMM, DatBase);
    x.access_size = SZ_BYTE;
    x.sign_extend = 1'b1;
    send_item(x);
    x.access_size = SZ_HALF;
    send_item(x);
    x.access_size = 2'd3;
    x.sign_extend = 1'b0;
    send_item(x);
    x = mk(OP_LOAD, 4'd3, 4'd0, MODE_IMM, DatBase + 1);
    x.access_size = SZ_BYTE;
    send_item(x);
    send_item(mk(OP_MOV, 4'd1, 4'd0, MODE_IMM, SignBit));
    send_item(mk(OP_MOV, 4'd2, 4'd0, MODE_IMM, AllOnes));
    send_item(mk(OP_SDIV, 4'd1, 4'd2, MODE_REG, 32'd0));
    send_item(mk(OP_DIV, 4'd1, 4'd0, MODE_REG, 32'd0));
    send_item(mk(OP_MOV, 4'd1, 4'd0, MODE_IMM, SignBit));
    send_item(mk(OP_DIV, 4'd1, 4'd2, MODE_REG, 32'd0));
    send_item(mk(OP_MOD, 4'd1, 4'd0, MODE_IMM, 32'd0));
    send_item(mk(OP_SMOD, 4'd1, 4'd2, MODE_REG, 32'd0));
    send_item(mk(OP_MOV, 4'd4, 4'd0, MODE_IMM, -32'sd7));
    send_item(mk(OP_SMOD, 4'd4, 4'd0, MODE_IMM, 32'd2));
    send_item(mk(OP_ASR, 4'd2, 4'd0, MODE_IMM, 32'd31));
    send_item(mk(OP_PUSH, 4'd1, 4'd0, MODE_IMM, 32'd0));
    send_item(mk(OP_POP, 4'd5, 4'd0, MODE_IMM, 32'd0));
    x = mk(OP_CMP, 4'd0, 4'd0, MODE_IMM, 32'd3);
    x.first_from_imm = 1'b1;
    x.imm_first = -32'sd5;
    send_item(x);
    x = mk(OP_MOV, 4'd6, 4'd0, MODE_IMM, 32'd9);
    x.condition = CondGt;
    send_item(x);
    x = mk(OP_JUMP, 4'd0, 4'd0, MODE_IMM, 32'd0);
    x.condition = CondNever;
    x.target = 32'd7;
    send_item(x);
    x = mk(OP_CALL, 4'd0, 4'd0, MODE_IMM, 32'd0);
    x.target = 32'd100;
    send_item(x);
    send_item(mk(OP_RET, RegLr, 4'd0, MODE_IMM, 32'd0));
    x = mk(OP_LEA, 4'd7, 4'd0, MODE_IMM, -32'sd16);
    x.target = 32'h1000;
    send_item(x);
    x = mk(OP_STORE, 4'd0, 4'd0, MODE_IMM, DatBase + 4);
    x.access_size = SZ_HALF;
    x.first_from_imm = 1'b1;
    x.imm_first = 32'hbeef;
    send_item(x);
    send_item(mk(OP_OUT, 4'd8, 4'd0, MODE_IMM, 32'd0));
    send_item(mk(OpUnused, 4'd8, 4'd0, MODE_IMM, 32'd0));
    send_item(mk(OP_NEG, 4'd1, 4'd0, MODE_IMM, 32'd0));
    send_item(mk(OP_ADD, 4'd8, 4'd7, 2'd3, 32'd5));

    for (int p = 0; p < NumPhases; p++) begin
      set_data_size(sizes[p]);
      send_idle = sends[p];
      recv_stall = stalls[p];
      if (p == 0) hold_cycles = 300;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_item(safe_instr());
      end
    end

    drain();
    case ($urandom_range(0, 3))
      0: send_item(mk(OP_KILL, 4'd0, 4'd0, MODE_IMM, 32'd0));
      1: send_item(mk(OP_HALT, 4'd0, 4'd0, MODE_IMM, 32'd0));
      2: begin
        send_item(mk(OP_MOV, RegLr, 4'd0, MODE_IMM, AllOnes));
        send_item(mk(OP_RET, 4'd0, 4'd0, MODE_IMM, 32'd0));
      end
      default: send_item(mk(OP_LOAD, 4'd0, 4'd0, MODE_IMM, 32'd0));
    endcase
    send_item(mk(OP_INC, 4'd0, 4'd0, MODE_IMM, 32'd0));
    send_item(preload(32'd9, 32'h3c));
    send_item(mk(OP_PUSH, 4'd0, 4'd0, MODE_IMM, 32'd0));

    drain();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
